@@ src/sdb_pkg.sv @@
// shared types, constants and register codes for the spectral deconvolution bin
`timescale 1ns / 1ps
`default_nettype none
package sdb_pkg;
	localparam int FRAC_BITS = 16;
	localparam int QUO_BITS  = 32;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIENER = 2'd1;
	localparam logic [1:0] REG_SMOOTH = 2'd2;

	localparam logic MODE_WIENER = 1'b0;
	localparam logic MODE_CLS    = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic        filter_mode;
		logic [31:0] wiener_noise_ratio;
		logic [31:0] smoothness_weight;
	} cfg_t;

	typedef struct packed {
		logic [63:0]         rem;
		logic [QUO_BITS-1:0] low;
		logic [QUO_BITS-1:0] quo;
		logic                neg;
		logic                ovf;
	} part_t;

	typedef struct packed {
		logic [63:0] den;
		logic        zero;
		part_t       re;
		part_t       im;
	} div_stage_t;
endpackage
`default_nettype wire

@@ src/sdb_if.sv @@
// valid/ready channel interfaces for spectrum bins and restored bins
`timescale 1ns / 1ps
`default_nettype none
interface sdb_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] spec_re;
	logic signed [31:0] spec_im;
	logic signed [31:0] psf_re;
	logic signed [31:0] psf_im;
	logic signed [31:0] lap_re;
	logic signed [31:0] lap_im;
	modport source (output valid, spec_re, spec_im, psf_re, psf_im, lap_re, lap_im,
		input ready);
	modport sink (input valid, spec_re, spec_im, psf_re, psf_im, lap_re, lap_im,
		output ready);
endinterface

interface sdb_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_re;
	logic signed [31:0] out_im;
	logic [1:0]         bin_status;
	modport source (output valid, out_re, out_im, bin_status, input ready);
	modport sink (input valid, out_re, out_im, bin_status, output ready);
endinterface
`default_nettype wire

@@ src/sdb_front.sv @@
// products, numerator, regularization, denominator and divider setup stages
`timescale 1ns / 1ps
`default_nettype none
module sdb_front import sdb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	sdb_in_if.sink     spectrum,
	input  wire logic  en_down,
	output logic       v_out,
	output div_stage_t stg_out
);
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [63:0] grhr_s1, gihi_s1, gihr_s1, grhi_s1, hr2_s1, hi2_s1, pr2_s1, pi2_s1;
	logic [63:0] nre_s2, nim_s2, hpow_s2, lpow_s2;
	logic        nre_neg_s2, nim_neg_s2;
	logic [63:0] nre_s3, nim_s3, hpow_s3, plo_s3, phi_s3;
	logic        nre_neg_s3, nim_neg_s3;
	logic [63:0] nre_s4, nim_s4, hpow_s4, rreg_s4;
	logic        nre_neg_s4, nim_neg_s4;
	logic [63:0] nre_s5, nim_s5, den_s5;
	logic        nre_neg_s5, nim_neg_s5;

	logic signed [64:0] sum_re, sum_im;
	logic [63:0] hpow_c, lpow_c, rreg_c, hi_part, lo_part;
	logic [64:0] add_a, add_b;
	logic [63:0] sh_re, sh_im, top_re, top_im;

	assign en6 = !v_out || en_down;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign spectrum.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_out <= 1'b0;
		end else begin
			if (en1) v_s1 <= spectrum.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_out <= v_s5;
		end
	end

	// stage 1: the eight 32x32 products
	always_ff @(posedge clk) begin
		if (en1 && spectrum.valid) begin
			grhr_s1 <= spectrum.spec_re * spectrum.psf_re;
			gihi_s1 <= spectrum.spec_im * spectrum.psf_im;
			gihr_s1 <= spectrum.spec_im * spectrum.psf_re;
			grhi_s1 <= spectrum.spec_re * spectrum.psf_im;
			hr2_s1  <= spectrum.psf_re * spectrum.psf_re;
			hi2_s1  <= spectrum.psf_im * spectrum.psf_im;
			pr2_s1  <= spectrum.lap_re * spectrum.lap_re;
			pi2_s1  <= spectrum.lap_im * spectrum.lap_im;
		end
	end

	// stage 2: numerators as sign and magnitude, powers
	always_comb begin
		sum_re = {grhr_s1[63], grhr_s1} + {gihi_s1[63], gihi_s1};
		sum_im = {gihr_s1[63], gihr_s1} - {grhi_s1[63], grhi_s1};
		hpow_c = 64'(hr2_s1) + 64'(hi2_s1);
		lpow_c = 64'(pr2_s1) + 64'(pi2_s1);
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			nre_neg_s2 <= sum_re[64];
			nim_neg_s2 <= sum_im[64];
			nre_s2     <= sum_re[64] ? 64'(-sum_re) : sum_re[63:0];
			nim_s2     <= sum_im[64] ? 64'(-sum_im) : sum_im[63:0];
			hpow_s2    <= hpow_c;
			lpow_s2    <= lpow_c;
		end
	end

	// stage 3: gamma times laplacian power, split in two halves
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			nre_s3 <= nre_s2; nim_s3 <= nim_s2;
			nre_neg_s3 <= nre_neg_s2; nim_neg_s3 <= nim_neg_s2;
			hpow_s3 <= hpow_s2;
			plo_s3 <= 64'(cfg.smoothness_weight) * 64'(lpow_s2[31:0]);
			phi_s3 <= 64'(cfg.smoothness_weight) * 64'(lpow_s2[63:32]);
		end
	end

	// stage 4: regularization term
	always_comb begin
		hi_part = phi_s3 << (32 - FRAC_BITS);
		lo_part = plo_s3 >> FRAC_BITS;
		add_a   = {1'b0, hi_part} + {1'b0, lo_part};
		if (cfg.filter_mode == MODE_WIENER) begin
			rreg_c = 64'(cfg.wiener_noise_ratio) << FRAC_BITS;
		end else if ((phi_s3 >> (32 + FRAC_BITS)) != 64'd0) begin
			rreg_c = '1;
		end else begin
			rreg_c = add_a[64] ? '1 : add_a[63:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			nre_s4 <= nre_s3; nim_s4 <= nim_s3;
			nre_neg_s4 <= nre_neg_s3; nim_neg_s4 <= nim_neg_s3;
			hpow_s4 <= hpow_s3;
			rreg_s4 <= rreg_c;
		end
	end

	// stage 5: saturating denominator
	assign add_b = {1'b0, hpow_s4} + {1'b0, rreg_s4};

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			nre_s5 <= nre_s4; nim_s5 <= nim_s4;
			nre_neg_s5 <= nre_neg_s4; nim_neg_s5 <= nim_neg_s4;
			den_s5 <= add_b[64] ? '1 : add_b[63:0];
		end
	end

	// stage 6: split scaled numerator, overflow when integer quotient needs more than 32 bits
	always_comb begin
		top_re = nre_s5 >> (QUO_BITS - FRAC_BITS);
		top_im = nim_s5 >> (QUO_BITS - FRAC_BITS);
		sh_re  = nre_s5 << FRAC_BITS;
		sh_im  = nim_s5 << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			stg_out.den    <= den_s5;
			stg_out.zero   <= (den_s5 == 64'd0);
			stg_out.re.ovf <= (top_re >= den_s5);
			stg_out.im.ovf <= (top_im >= den_s5);
			stg_out.re.rem <= (top_re >= den_s5) ? 64'd0 : top_re;
			stg_out.im.rem <= (top_im >= den_s5) ? 64'd0 : top_im;
			stg_out.re.low <= sh_re[QUO_BITS-1:0];
			stg_out.im.low <= sh_im[QUO_BITS-1:0];
			stg_out.re.quo <= '0;
			stg_out.im.quo <= '0;
			stg_out.re.neg <= nre_neg_s5;
			stg_out.im.neg <= nim_neg_s5;
		end
	end
endmodule
`default_nettype wire

@@ src/sdb_div_stage.sv @@
// one registered restoring division step for both result parts
`timescale 1ns / 1ps
`default_nettype none
module sdb_div_stage import sdb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       v_in,
	input  wire div_stage_t stg_in,
	output logic            en_up,
	input  wire logic       en_down,
	output logic            v_out,
	output div_stage_t      stg_out
);
	div_stage_t nxt;
	logic [64:0] t_re, t_im, d_re, d_im;

	assign en_up = !v_out || en_down;

	always_comb begin
		nxt  = stg_in;
		t_re = {stg_in.re.rem, stg_in.re.low[QUO_BITS-1]};
		t_im = {stg_in.im.rem, stg_in.im.low[QUO_BITS-1]};
		d_re = t_re - {1'b0, stg_in.den};
		d_im = t_im - {1'b0, stg_in.den};
		nxt.re.low = stg_in.re.low << 1;
		nxt.im.low = stg_in.im.low << 1;
		if (t_re >= {1'b0, stg_in.den}) begin
			nxt.re.rem = d_re[63:0];
			nxt.re.quo = {stg_in.re.quo[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt.re.rem = t_re[63:0];
			nxt.re.quo = {stg_in.re.quo[QUO_BITS-2:0], 1'b0};
		end
		if (t_im >= {1'b0, stg_in.den}) begin
			nxt.im.rem = d_im[63:0];
			nxt.im.quo = {stg_in.im.quo[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt.im.rem = t_im[63:0];
			nxt.im.quo = {stg_in.im.quo[QUO_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en_up) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en_up && v_in) begin
			stg_out <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ src/spectral_deconvolution_bin.sv @@
// top level of the spectral deconvolution bin filter
`timescale 1ns / 1ps
`default_nettype none
// Restores one complex frequency bin per transaction as G*conj(H)/(|H|^2+R), where
// R is the Wiener constant K (filter_mode 0) or gamma*|P|^2 (filter_mode 1); all
// values are signed Q15.16 and results saturate (bin_status 1) or are forced to
// zero when the denominator is zero (bin_status 2). The block takes one bin every
// cycle unless back-pressure stalls it; each bin passes through six setup stages
// (products, numerators, regularization, denominator, divider setup), one stage
// per quotient bit of the 32-stage restoring divider that both result parts share,
// and the output register. Each stage holds its bin while the next is full, so
// bubbles close up under back-pressure and nothing is dropped or repeated.
// Configuration is written on wr_en with wr_index 0, 1, 2 selecting filter_mode,
// wiener_noise_ratio and smoothness_weight; write only while the pipeline is empty.
module spectral_deconvolution_bin import sdb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	sdb_in_if.sink           spectrum,
	sdb_out_if.source        restored
);
	cfg_t       cfg_q;
	div_stage_t stg [0:QUO_BITS];
	logic       v   [0:QUO_BITS];
	logic       en  [0:QUO_BITS];

	logic        out_v_q;
	logic [31:0] out_re_q, out_im_q;
	logic [1:0]  status_q;

	logic [31:0] res_re, res_im;
	logic        sat_re, sat_im;
	logic [1:0]  status_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode        <= MODE_CLS;
			cfg_q.wiener_noise_ratio <= 32'd655;
			cfg_q.smoothness_weight  <= 32'd655;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE:   cfg_q.filter_mode        <= wr_data[0];
				REG_WIENER: cfg_q.wiener_noise_ratio <= wr_data;
				REG_SMOOTH: cfg_q.smoothness_weight  <= wr_data;
				default: ;
			endcase
		end
	end

	sdb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.spectrum(spectrum),
		.en_down (en[0]),
		.v_out   (v[0]),
		.stg_out (stg[0])
	);

	// one quotient bit per stage
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		sdb_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (v[i]),
			.stg_in (stg[i]),
			.en_up  (en[i]),
			.en_down(en[i+1]),
			.v_out  (v[i+1]),
			.stg_out(stg[i+1])
		);
	end

	// output register stage enable closes the ready chain
	assign en[QUO_BITS] = !out_v_q || restored.ready;

	// saturate each part to its signed limit, then apply the sign
	function automatic logic [31:0] finish(input part_t p, output logic sat);
		logic [31:0] lim;
		logic [31:0] mag;
		lim = p.neg ? NEG_LIMIT : POS_LIMIT;
		sat = p.ovf || (p.quo > lim);
		mag = sat ? lim : p.quo;
		return p.neg ? 32'(-mag) : mag;
	endfunction

	always_comb begin
		res_re = finish(stg[QUO_BITS].re, sat_re);
		res_im = finish(stg[QUO_BITS].im, sat_im);
		if (stg[QUO_BITS].zero) begin
			status_c = ST_ZERO;
		end else if (sat_re || sat_im) begin
			status_c = ST_SAT;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en[QUO_BITS]) begin
			out_v_q <= v[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en[QUO_BITS] && v[QUO_BITS]) begin
			out_re_q <= stg[QUO_BITS].zero ? 32'd0 : res_re;
			out_im_q <= stg[QUO_BITS].zero ? 32'd0 : res_im;
			status_q <= status_c;
		end
	end

	assign restored.valid      = out_v_q;
	assign restored.out_re     = out_re_q;
	assign restored.out_im     = out_im_q;
	assign restored.bin_status = status_q;

	// zero denominator forces both parts to zero
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		restored.valid && restored.bin_status == ST_ZERO |->
			restored.out_re == 32'sd0 && restored.out_im == 32'sd0)
		else $error("zero denominator bin with nonzero output");

	// a saturated bin has at least one part at a limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		restored.valid && restored.bin_status == ST_SAT |->
			restored.out_re == POS_LIMIT || restored.out_re == NEG_LIMIT ||
			restored.out_im == POS_LIMIT || restored.out_im == NEG_LIMIT)
		else $error("saturated status without a limit value");

	// the output stage only fills from a valid last divider stage
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q && !v[QUO_BITS] |=> !out_v_q)
		else $error("output became valid without a bin from the divider");
endmodule
`default_nettype wire

@@ bench/spectral_deconvolution_bin_test.sv @@
// self-checking bench for the spectral deconvolution bin filter
`timescale 1ns / 1ps
module spectral_deconvolution_bin_test import sdb_pkg::*;;

	localparam int CYCLE_LIMIT = 400000;
	localparam int QUIET_CYCLES = 48;  // longer than the pipeline
	localparam int TAIL_CYCLES = 60;

	typedef enum logic [1:0] {STEP_BIN, STEP_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct {
		logic signed [31:0] gr, gi, hr, hi, pr, pi;
	} bin_t;

	typedef struct {
		logic signed [31:0] re, im;
		logic [1:0]         status;
	} restored_t;

	typedef struct {
		step_kind_t  kind;
		bin_t        bin;
		logic [1:0]  windex;
		logic [31:0] wdata;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;

	sdb_in_if  spectrum_ch ();
	sdb_out_if restored_ch ();

	spectral_deconvolution_bin dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.spectrum (spectrum_ch),
		.restored (restored_ch)
	);

	step_t     stim_q[$];
	restored_t restored_q[$];
	cfg_t      shadow_cfg;
	bin_t      on_bus;
	int        mismatches;
	int        quiet;
	int        burst_left;
	int        gap_left;
	int        cycles;
	int        stall_cnt;
	int        stall_style;

	// |x|^2 of one complex value, exact in 64 bits
	function automatic logic [63:0] power_of(logic signed [31:0] re, logic signed [31:0] im);
		logic signed [63:0] r;
		logic signed [63:0] i;
		logic [63:0] ru;
		logic [63:0] iu;
		r = re;
		i = im;
		ru = r < 0 ? -r : r;
		iu = i < 0 ? -i : i;
		return ru * ru + iu * iu;
	endfunction

	// one result part: |num| scaled up by the fraction bits over the denominator, saturated
	function automatic logic [31:0] quotient_part(logic signed [64:0] num, logic [63:0] den,
		inout logic sat);
		logic         neg;
		logic [64:0]  mag;
		logic [127:0] q;
		logic [127:0] limit;
		neg = num < 0;
		mag = neg ? -num : num;
		q = ({63'd0, mag} << FRAC_BITS) / {64'd0, den};
		limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > limit) begin
			q = limit;
			sat = 1'b1;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	// expected restored bin G*conj(H)/(|H|^2+R) under the given register settings
	function automatic restored_t restore_bin(cfg_t c, bin_t b);
		restored_t          res;
		logic [63:0]        reg_term;
		logic [127:0]       wide;
		logic [64:0]        den_sum;
		logic [63:0]        den;
		logic signed [63:0] p_rr, p_ii, p_ir, p_ri;
		logic signed [64:0] num_re, num_im;
		logic               sat;
		if (c.filter_mode == MODE_WIENER)
			reg_term = {32'd0, c.wiener_noise_ratio} << FRAC_BITS;
		else begin
			wide = ({96'd0, c.smoothness_weight} * {64'd0, power_of(b.pr, b.pi)}) >> FRAC_BITS;
			reg_term = wide[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
		end
		den_sum = {1'b0, power_of(b.hr, b.hi)} + {1'b0, reg_term};
		den = den_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : den_sum[63:0];
		if (den == 0) begin
			res.re = 0;
			res.im = 0;
			res.status = ST_ZERO;
			return res;
		end
		p_rr = 64'(b.gr) * 64'(b.hr);
		p_ii = 64'(b.gi) * 64'(b.hi);
		p_ir = 64'(b.gi) * 64'(b.hr);
		p_ri = 64'(b.gr) * 64'(b.hi);
		num_re = 65'(p_rr) + 65'(p_ii);
		num_im = 65'(p_ir) - 65'(p_ri);
		sat = 1'b0;
		res.re = quotient_part(num_re, den, sat);
		res.im = quotient_part(num_im, den, sat);
		res.status = sat ? ST_SAT : ST_OK;
		return res;
	endfunction

	function automatic logic [31:0] pick_field();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			3: case ($urandom_range(0, 6))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'hFFFF_FFFF;
				3: v = 32'h0001_0000;
				4: v = 32'hFFFF_0000;
				5: v = 32'd1;
				default: v = 32'd0;
			endcase
			4: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] pick_register();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic push_bin(logic [31:0] gr, logic [31:0] gi, logic [31:0] hr,
		logic [31:0] hi, logic [31:0] pr, logic [31:0] pi);
		step_t s;
		s.kind = STEP_BIN;
		s.bin.gr = gr; s.bin.gi = gi; s.bin.hr = hr;
		s.bin.hi = hi; s.bin.pr = pr; s.bin.pi = pi;
		s.windex = REG_MODE;
		s.wdata = 0;
		stim_q.push_back(s);
	endtask

	task automatic push_step(step_kind_t kind, logic [1:0] idx, logic [31:0] data);
		step_t s;
		s.kind = kind;
		s.bin = '{default: 0};
		s.windex = idx;
		s.wdata = data;
		stim_q.push_back(s);
	endtask

	// clock, reset and every block input at a known value from time zero
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MODE;
		wr_data = 0;
		spectrum_ch.valid = 1'b0;
		spectrum_ch.spec_re = 0;
		spectrum_ch.spec_im = 0;
		spectrum_ch.psf_re = 0;
		spectrum_ch.psf_im = 0;
		spectrum_ch.lap_re = 0;
		spectrum_ch.lap_im = 0;
		restored_ch.ready = 1'b0;
		repeat (7) begin
			#4 clk = 1'b1;
			#4 clk = 1'b0;
		end
		arst_n = 1'b1;
		forever #4 clk = ~clk;
	end

	// stimulus plan, then the end-of-run wait and verdict
	initial begin
		// reset settings: least squares, gamma about 0.01
		push_bin(0, 0, 0, 0, 0, 0);                              // zero denominator
		push_bin(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);      // H zero, R nonzero
		push_bin(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 0, 0);
		push_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0, 0);      // saturates high
		push_bin(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0);      // saturates both ways
		push_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		push_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
		// wiener, K zero
		push_step(STEP_WRITE, REG_MODE, {31'd0, MODE_WIENER});
		push_step(STEP_WRITE, REG_WIENER, 0);
		push_bin(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 0);  // zero denominator
		push_bin(32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
		push_bin(32'h8000_0000, 0, 32'h0000_0001, 0, 0, 0);
		// wiener, K at its top
		push_step(STEP_WRITE, REG_WIENER, 32'hFFFF_FFFF);
		push_bin(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		push_bin(32'h0001_0000, 0, 0, 0, 0, 0);
		// least squares, gamma zero, then at its top
		push_step(STEP_WRITE, REG_MODE, {31'd0, MODE_CLS});
		push_step(STEP_WRITE, REG_SMOOTH, 0);
		push_bin(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		push_bin(32'h0001_0000, 0, 32'h0000_8000, 0, 32'h7FFF_FFFF, 0);
		push_step(STEP_WRITE, REG_SMOOTH, 32'hFFFF_FFFF);
		push_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 0, 32'h8000_0000, 32'h8000_0000);
		push_bin(32'h7FFF_FFFF, 0, 0, 0, 32'h0000_0001, 0);
		push_bin(32'h0100_0000, 32'h0100_0000, 32'h0000_0100, 0, 0, 0);

		// random phases, each under fresh register settings
		for (int ph = 0; ph < 6; ph++) begin
			push_step(STEP_WRITE, REG_MODE, {31'd0, ph[0]});
			push_step(STEP_WRITE, REG_WIENER, pick_register());
			push_step(STEP_WRITE, REG_SMOOTH, pick_register());
			for (int n = 0; n < 72; n++) begin
				if (ph == 2 && n == 36) push_step(STEP_DRAIN, REG_MODE, 0);
				push_bin(pick_field(), pick_field(), pick_field(),
					pick_field(), pick_field(), pick_field());
			end
		end

		wait (arst_n);
		while (stim_q.size() != 0 || spectrum_ch.valid || restored_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("spectral_deconvolution_bin_test passed");
		else
			$display("spectral_deconvolution_bin_test failed");
		$finish;
	end

	// driver: bursts of bins, register writes only once the pipeline has drained
	always @(posedge clk or negedge arst_n) begin
		logic        valid_n;
		logic        wr_en_n;
		logic [1:0]  idx_n;
		logic [31:0] data_n;
		bin_t        bin_n;
		step_t       head;
		if (!arst_n) begin
			spectrum_ch.valid <= 1'b0;
			wr_en <= 1'b0;
			shadow_cfg.filter_mode = MODE_CLS;
			shadow_cfg.wiener_noise_ratio = 655;
			shadow_cfg.smoothness_weight = 655;
			quiet = 0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			// an accepted transaction becomes an expected restored bin
			if (spectrum_ch.valid && spectrum_ch.ready)
				restored_q.push_back(restore_bin(shadow_cfg, on_bus));
			if (spectrum_ch.valid || restored_q.size() != 0)
				quiet = 0;
			else
				quiet++;
			valid_n = spectrum_ch.valid && !spectrum_ch.ready;
			bin_n = on_bus;
			wr_en_n = 1'b0;
			idx_n = wr_index;
			data_n = wr_data;
			if (!valid_n && stim_q.size() != 0) begin
				head = stim_q[0];
				case (head.kind)
					STEP_BIN: begin
						if (gap_left > 0)
							gap_left--;
						else begin
							void'(stim_q.pop_front());
							bin_n = head.bin;
							valid_n = 1'b1;
							burst_left--;
							if (burst_left <= 0) begin
								burst_left = $urandom_range(1, 40);
								gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
							end
						end
					end
					STEP_WRITE: begin
						if (quiet >= QUIET_CYCLES) begin
							void'(stim_q.pop_front());
							case (head.windex)
								REG_MODE:   shadow_cfg.filter_mode = head.wdata[0];
								REG_WIENER: shadow_cfg.wiener_noise_ratio = head.wdata;
								REG_SMOOTH: shadow_cfg.smoothness_weight = head.wdata;
								default: ;
							endcase
							wr_en_n = 1'b1;
							idx_n = head.windex;
							data_n = head.wdata;
						end
					end
					default: begin
						// hold off until every restored bin is back
						if (quiet >= QUIET_CYCLES) void'(stim_q.pop_front());
					end
				endcase
			end
			on_bus = bin_n;
			spectrum_ch.valid <= valid_n;
			spectrum_ch.spec_re <= bin_n.gr;
			spectrum_ch.spec_im <= bin_n.gi;
			spectrum_ch.psf_re <= bin_n.hr;
			spectrum_ch.psf_im <= bin_n.hi;
			spectrum_ch.lap_re <= bin_n.pr;
			spectrum_ch.lap_im <= bin_n.pi;
			wr_en <= wr_en_n;
			wr_index <= idx_n;
			wr_data <= data_n;
		end
	end

	// monitor: compare each restored bin with the oldest expectation; stall on a pattern
	always @(posedge clk or negedge arst_n) begin
		restored_t want;
		if (!arst_n) begin
			restored_ch.ready <= 1'b0;
			mismatches = 0;
			stall_cnt = 0;
			stall_style = 0;
		end else begin
			if (restored_ch.valid && restored_ch.ready) begin
				if (restored_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected restored bin re=%h im=%h status=%0d",
							restored_ch.out_re, restored_ch.out_im, restored_ch.bin_status);
				end else begin
					want = restored_q.pop_front();
					if (restored_ch.out_re !== want.re || restored_ch.out_im !== want.im ||
						restored_ch.bin_status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected re=%h im=%h status=%0d, got re=%h im=%h status=%0d",
								want.re, want.im, want.status, restored_ch.out_re,
								restored_ch.out_im, restored_ch.bin_status);
					end
				end
			end
			// stall style, drawn at random from: none, random, periodic
			stall_cnt++;
			if (stall_cnt % 96 == 0) stall_style = $urandom_range(0, 2);
			case (stall_style)
				0: restored_ch.ready <= 1'b1;
				1: restored_ch.ready <= $urandom_range(0, 9) >= 3;
				default: restored_ch.ready <= (stall_cnt % 7) < 4;
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("spectral_deconvolution_bin_test failed");
			$finish;
		end
	end

	initial cycles = 0;
endmodule
